>>> hw/rtl/mmsd_pkg.sv
package mmsd_pkg;

  localparam int unsigned NBITS = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_H     = 2'd0,
    CMD_LOAD_Y     = 2'd1,
    CMD_LOAD_PRIOR = 2'd2,
    CMD_START      = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [4:0]         row_index;
    logic [1:0]         col_index;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic signed [15:0] llr_in;
  } in_t;

  typedef struct packed {
    logic [4:0]         bit_index;
    logic signed [31:0] llr_out;
    logic               last;
  } out_t;

  // sweep geometry after clamping
  typedef struct packed {
    logic [3:0] ntx;
    logic [3:0] nrx;
    logic [2:0] h;
    logic [5:0] tbits;
    logic [4:0] ndig;
  } geo_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LEV, OP_PRI, OP_ROW, OP_MAC, OP_SQR, OP_SQI,
    OP_ACC, OP_PLO, OP_PHI, OP_FULL, OP_UPDM, OP_UPDB, OP_STEP, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       load;
    logic [4:0] j;
    logic [5:0] k;
    logic [3:0] kd;
    logic [1:0] kb;
    logic [3:0] r;
    logic [3:0] i;
  } dp_cmd_t;

  typedef struct packed {
    logic last_hyp;
  } dp_sts_t;

endpackage

>>> hw/rtl/mmsd_ctrl.sv
module mmsd_ctrl import mmsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  cmd_e    in_command_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  geo_t    geo_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_LEV, S_PRI, S_ROW, S_MAC, S_SQR, S_SQI,
    S_ACC, S_PLO, S_PHI, S_FULL, S_UPDM, S_UPDB, S_STEP, S_OUT
  } state_e;

  state_e     state_q;
  logic [4:0] j_q;
  logic [5:0] k_q;
  logic [3:0] kd_q;
  logic [1:0] kb_q;
  logic [3:0] r_q;
  logic [3:0] i_q;
  logic       ov_q;
  logic [2:0] kb_inc;
  logic       kb_wrap;
  logic       out_adv;

  assign kb_inc  = {1'b0, kb_q} + 3'd1;
  assign kb_wrap = (kb_inc == geo_i.h);
  assign out_adv = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      k_q     <= '0;
      kd_q    <= '0;
      kb_q    <= '0;
      r_q     <= '0;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_command_i == CMD_START) state_q <= S_INIT;
        end
        S_INIT: begin
          j_q     <= '0;
          state_q <= S_LEV;
        end
        S_LEV: begin
          j_q <= j_q + 5'd1;
          if (j_q + 5'd1 == geo_i.ndig) begin
            k_q     <= '0;
            kd_q    <= '0;
            kb_q    <= '0;
            state_q <= S_PRI;
          end
        end
        S_PRI: begin
          k_q <= k_q + 6'd1;
          if (kb_wrap) begin
            kb_q <= '0;
            kd_q <= kd_q + 4'd1;
          end else begin
            kb_q <= kb_inc[1:0];
          end
          if (k_q + 6'd1 == geo_i.tbits) begin
            r_q     <= '0;
            state_q <= S_ROW;
          end
        end
        S_ROW: begin
          i_q     <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          i_q <= i_q + 4'd1;
          if (i_q + 4'd1 == geo_i.ntx) state_q <= S_SQR;
        end
        S_SQR: state_q <= S_SQI;
        S_SQI: state_q <= S_ACC;
        S_ACC: begin
          r_q <= r_q + 4'd1;
          if (r_q + 4'd1 == geo_i.nrx) state_q <= S_PLO;
          else state_q <= S_ROW;
        end
        S_PLO: state_q <= S_PHI;
        S_PHI: state_q <= S_FULL;
        S_FULL: begin
          k_q     <= '0;
          kd_q    <= '0;
          kb_q    <= '0;
          state_q <= S_UPDM;
        end
        S_UPDM: state_q <= S_UPDB;
        S_UPDB: begin
          k_q <= k_q + 6'd1;
          if (kb_wrap) begin
            kb_q <= '0;
            kd_q <= kd_q + 4'd1;
          end else begin
            kb_q <= kb_inc[1:0];
          end
          if (k_q + 6'd1 == geo_i.tbits) state_q <= S_STEP;
          else state_q <= S_UPDM;
        end
        S_STEP: begin
          if (sts_i.last_hyp) begin
            k_q     <= '0;
            state_q <= S_OUT;
          end else begin
            j_q     <= '0;
            state_q <= S_LEV;
          end
        end
        S_OUT: begin
          if (out_adv) begin
            if (k_q != geo_i.tbits) begin
              ov_q <= 1'b1;
              k_q  <= k_q + 6'd1;
            end else begin
              ov_q    <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.j    = j_q;
    cmd_o.k    = k_q;
    cmd_o.kd   = kd_q;
    cmd_o.kb   = kb_q;
    cmd_o.r    = r_q;
    cmd_o.i    = i_q;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_INIT: cmd_o.op = OP_INIT;
      S_LEV:  cmd_o.op = OP_LEV;
      S_PRI:  cmd_o.op = OP_PRI;
      S_ROW:  cmd_o.op = OP_ROW;
      S_MAC:  cmd_o.op = OP_MAC;
      S_SQR:  cmd_o.op = OP_SQR;
      S_SQI:  cmd_o.op = OP_SQI;
      S_ACC:  cmd_o.op = OP_ACC;
      S_PLO:  cmd_o.op = OP_PLO;
      S_PHI:  cmd_o.op = OP_PHI;
      S_FULL: cmd_o.op = OP_FULL;
      S_UPDM: cmd_o.op = OP_UPDM;
      S_UPDB: cmd_o.op = OP_UPDB;
      S_STEP: cmd_o.op = OP_STEP;
      S_OUT:  cmd_o.op = (out_adv && k_q != geo_i.tbits) ? OP_OUT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;

endmodule

>>> hw/rtl/mmsd_dp.sv
module mmsd_dp import mmsd_pkg::*; #(
  parameter int unsigned MAX_TX = 4,
  parameter int unsigned MAX_RX = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  in_t         in_data_i,
  input  geo_t        geo_i,
  input  logic [15:0] inv_nvar_i,
  input  logic        log_map_i,
  input  logic [63:0] pam_lo_i,
  input  logic [63:0] pam_hi_i,
  output dp_sts_t     sts_o,
  output out_t        out_data_o
);

  localparam int unsigned TX_AW = (MAX_TX > 1) ? $clog2(MAX_TX) : 1;
  localparam int unsigned RX_AW = (MAX_RX > 1) ? $clog2(MAX_RX) : 1;
  localparam int unsigned NDIG  = 2 * MAX_TX;
  localparam int unsigned DG_AW = $clog2(NDIG);
  localparam int unsigned RW    = 26 + $clog2(MAX_TX);
  localparam int unsigned DW    = 2 * RW + $clog2(MAX_RX) + 1;
  localparam int unsigned PW    = 28;
  localparam int unsigned FW    = 54;

  localparam logic [15:0] JAC [16] = '{
    16'd45426, 16'd37745, 16'd31069, 16'd25354, 16'd20530, 16'd16510, 16'd13200, 16'd10500,
    16'd8318,  16'd6567,  16'd5170,  16'd4061,  16'd3184,  16'd2493,  16'd1950,  16'd1523
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] max_star(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic lm);
    logic signed [63:0] mx;
    logic signed [32:0] d;
    logic [32:0]        ad;
    mx = (a > b) ? 64'(a) : 64'(b);
    d  = 33'(a) - 33'(b);
    ad = (d < 0) ? -d : d;
    if (lm && ad[32:18] == '0) mx = mx + 64'(JAC[ad[17:14]]);
    return sat32(mx);
  endfunction

  // level index is the digit with its h bits reversed
  function automatic logic signed [7:0] pam_level(input logic [3:0] p, input logic [2:0] h,
                                                  input logic [127:0] tab);
    logic [3:0] idx;
    case (h)
      3'd1:    idx = {3'b000, p[0]};
      3'd2:    idx = {2'b00, p[0], p[1]};
      3'd3:    idx = {1'b0, p[0], p[1], p[2]};
      default: idx = {p[0], p[1], p[2], p[3]};
    endcase
    return tab[{idx, 3'b000} +: 8];
  endfunction

  logic [31:0]        ch_q  [MAX_RX][MAX_TX];
  logic [31:0]        rcv_q [MAX_RX];
  logic [15:0]        pri_q [NBITS];
  logic [3:0]         dig_q [NDIG];
  logic [3:0]         dig_nx [NDIG];
  logic signed [7:0]  lev_q [MAX_TX][2];
  logic signed [31:0] best1_q [NBITS];
  logic signed [31:0] best0_q [NBITS];
  logic [NBITS-1:0]   v1_q;
  logic [NBITS-1:0]   v0_q;
  logic signed [RW-1:0] rre_q;
  logic signed [RW-1:0] rim_q;
  logic [2*RW-1:0]    sq_q;
  logic [DW-1:0]      dist_q;
  logic signed [PW-1:0] prior_q;
  logic [39:0]        plo_q;
  logic [39:0]        phi_q;
  logic signed [FW-1:0] full_q;
  logic signed [31:0] m_q;
  logic               bit_q;
  out_t               out_q;

  logic [RX_AW-1:0]   ri;
  logic [TX_AW-1:0]   ii;
  logic [TX_AW-1:0]   jp;
  logic [4:0]         kk;
  logic [DG_AW-1:0]   dig_a;
  logic [3:0]         dsel;
  logic               bit_v;
  logic signed [15:0] pri_v;
  logic signed [22:0] t_w;
  logic signed [23:0] term_w;
  logic signed [15:0] hre;
  logic signed [15:0] him;
  logic signed [7:0]  lva;
  logic signed [7:0]  lvb;
  logic signed [23:0] p_ra;
  logic signed [23:0] p_ib;
  logic signed [23:0] p_rb;
  logic signed [23:0] p_ia;
  logic signed [2*RW-1:0] sq_re;
  logic signed [2*RW-1:0] sq_im;
  logic [47:0]        d8c;
  logic [63:0]        pen_w;
  logic [3:0]         maxd;
  logic               carry;
  logic               all_max;
  logic [RX_AW-1:0]   ld_row;
  logic [TX_AW-1:0]   ld_col;

  assign ri     = cmd_i.r[RX_AW-1:0];
  assign ii     = cmd_i.i[TX_AW-1:0];
  assign jp     = TX_AW'(cmd_i.j >> 1);
  assign kk     = cmd_i.k[4:0];
  assign dig_a  = (cmd_i.op == OP_LEV) ? cmd_i.j[DG_AW-1:0] : cmd_i.kd[DG_AW-1:0];
  assign dsel   = dig_q[dig_a];
  assign bit_v  = dsel[cmd_i.kb];
  assign pri_v  = pri_q[kk];
  assign t_w    = signed'({pri_v, 7'b0000000});
  assign term_w = bit_v ? 24'(t_w) : -24'(t_w);
  assign hre    = ch_q[ri][ii][15:0];
  assign him    = ch_q[ri][ii][31:16];
  assign lva    = lev_q[ii][0];
  assign lvb    = lev_q[ii][1];
  assign p_ra   = hre * lva;
  assign p_ib   = him * lvb;
  assign p_rb   = hre * lvb;
  assign p_ia   = him * lva;
  assign sq_re  = rre_q * rre_q;
  assign sq_im  = rim_q * rim_q;
  assign d8c    = (64'(dist_q[DW-1:8]) > 64'h0000_8000_0000_0000) ?
                  48'h8000_0000_0000 : 48'(dist_q[DW-1:8]);
  assign pen_w  = {phi_q, 24'b0} + {24'b0, plo_q};
  assign maxd   = 4'((5'd1 << geo_i.h) - 5'd1);
  assign ld_row = RX_AW'(in_data_i.row_index);
  assign ld_col = TX_AW'(in_data_i.col_index);

  // odometer, last digit fastest
  always_comb begin
    carry   = 1'b1;
    all_max = 1'b1;
    for (int d = NDIG - 1; d >= 0; d--) begin
      dig_nx[d] = dig_q[d];
      if (d < int'(geo_i.ndig)) begin
        if (dig_q[d] != maxd) all_max = 1'b0;
        if (carry) begin
          if (dig_q[d] == maxd) begin
            dig_nx[d] = '0;
          end else begin
            dig_nx[d] = dig_q[d] + 4'd1;
            carry     = 1'b0;
          end
        end
      end
    end
  end

  assign sts_o.last_hyp = all_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NDIG; d++) dig_q[d] <= '0;
      v1_q <= '0;
      v0_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_INIT: begin
          for (int d = 0; d < NDIG; d++) dig_q[d] <= '0;
          v1_q <= '0;
          v0_q <= '0;
        end
        OP_STEP: dig_q <= dig_nx;
        OP_UPDB: begin
          if (bit_q) v1_q[kk] <= 1'b1;
          else v0_q[kk] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (in_data_i.command)
        CMD_LOAD_H: begin
          if (32'(in_data_i.row_index) < MAX_RX && 32'(in_data_i.col_index) < MAX_TX)
            ch_q[ld_row][ld_col] <= {in_data_i.value_im, in_data_i.value_re};
        end
        CMD_LOAD_Y: begin
          if (32'(in_data_i.row_index) < MAX_RX)
            rcv_q[ld_row] <= {in_data_i.value_im, in_data_i.value_re};
        end
        CMD_LOAD_PRIOR: pri_q[in_data_i.row_index] <= in_data_i.llr_in;
        default: ;
      endcase
    end
    case (cmd_i.op)
      OP_INIT, OP_STEP: begin
        prior_q <= '0;
        dist_q  <= '0;
      end
      OP_LEV: lev_q[jp][cmd_i.j[0]] <= pam_level(dsel, geo_i.h, {pam_hi_i, pam_lo_i});
      OP_PRI: prior_q <= prior_q + PW'(term_w);
      OP_ROW: begin
        rre_q <= RW'(signed'(rcv_q[ri][15:0]));
        rim_q <= RW'(signed'(rcv_q[ri][31:16]));
      end
      OP_MAC: begin
        rre_q <= rre_q - (RW'(p_ra) - RW'(p_ib));
        rim_q <= rim_q - (RW'(p_rb) + RW'(p_ia));
      end
      OP_SQR: sq_q <= sq_re;
      OP_SQI: begin
        sq_q   <= sq_im;
        dist_q <= dist_q + DW'(sq_q);
      end
      OP_ACC: dist_q <= dist_q + DW'(sq_q);
      OP_PLO: plo_q <= 40'(d8c[23:0]) * 40'(inv_nvar_i);
      OP_PHI: phi_q <= 40'(d8c[47:24]) * 40'(inv_nvar_i);
      OP_FULL: full_q <= FW'(prior_q) - signed'({2'b00, pen_w[63:12]});
      OP_UPDM: begin
        m_q   <= sat32(64'(full_q) - 64'(term_w));
        bit_q <= bit_v;
      end
      OP_UPDB: begin
        if (bit_q) best1_q[kk] <= v1_q[kk] ? max_star(best1_q[kk], m_q, log_map_i) : m_q;
        else best0_q[kk] <= v0_q[kk] ? max_star(best0_q[kk], m_q, log_map_i) : m_q;
      end
      OP_OUT: begin
        out_q.bit_index <= kk;
        out_q.llr_out   <= sat32(64'(best1_q[kk]) - 64'(best0_q[kk]));
        out_q.last      <= (cmd_i.k == geo_i.tbits - 6'd1);
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

>>> hw/rtl/mimo_map_soft_detector_core.sv
// exhaustive max-log / log-map soft detector for one slice of a square-qam mimo link
// input channel (in_valid_i / in_stall_o / in_data_i): load items write the channel
//   matrix, the received vector or a prior llr, one transfer per cycle while idle;
//   a start item runs the full hypothesis sweep and the input stalls until the
//   last llr of the slice has been transferred
// output channel (out_valid_o / out_stall_i / out_data_o): one llr per bit in bit
//   order, last set on the final one, one transfer per cycle when not stalled;
//   a stalled result holds in the output register
// configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; the user
//   must write only while idle, which the block itself does not enforce
// per hypothesis the sequencer steps one digit, prior bit or antenna per cycle
//   through one complex mac, one squarer and a 24x16 penalty multiplier used twice
// the sweep covers 2^tbits hypotheses, with tbits = 2*ntx*(bits_per_symbol/2)
// reset: configuration returns to its defaults, the sequencer goes idle;
//   the channel, received and prior stores hold nothing defined until written
module mimo_map_soft_detector_core import mmsd_pkg::*; #(
  parameter int unsigned MAX_TX              = 4,
  parameter int unsigned MAX_RX              = 4,
  parameter int unsigned MAX_BITS_PER_SYMBOL = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [2:0] {
    REG_TX_ANT, REG_RX_ANT, REG_BPS, REG_INV_NVAR, REG_LOG_MAP, REG_PAM_LO, REG_PAM_HI
  } reg_e;

  logic [2:0]  tx_q;
  logic [2:0]  rx_q;
  logic [3:0]  bps_q;
  logic [15:0] inv_q;
  logic        lm_q;
  logic [63:0] pam_lo_q;
  logic [63:0] pam_hi_q;

  logic [3:0]  bps_c;
  logic [2:0]  h_c;
  logic [3:0]  ntx0;
  logic [4:0]  lim;
  logic [3:0]  ntx_c;
  logic [3:0]  nrx_c;
  geo_t        geo;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= 3'd2;
      rx_q     <= 3'd2;
      bps_q    <= 4'd4;
      inv_q    <= 16'd4096;
      lm_q     <= 1'b0;
      pam_lo_q <= '0;
      pam_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_TX_ANT:   tx_q     <= cfg_data_i[2:0];
        REG_RX_ANT:   rx_q     <= cfg_data_i[2:0];
        REG_BPS:      bps_q    <= cfg_data_i[3:0];
        REG_INV_NVAR: inv_q    <= cfg_data_i[15:0];
        REG_LOG_MAP:  lm_q     <= cfg_data_i[0];
        REG_PAM_LO:   pam_lo_q <= cfg_data_i;
        REG_PAM_HI:   pam_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the sweep geometry
  always_comb begin
    bps_c = (bps_q > 4'(MAX_BITS_PER_SYMBOL)) ? 4'(MAX_BITS_PER_SYMBOL) : bps_q;
    h_c   = bps_c[3:1];
    if (h_c == 3'd0) h_c = 3'd1;
    if (h_c > 3'd4) h_c = 3'd4;
    if (tx_q == 3'd0) ntx0 = 4'd1;
    else if ({1'b0, tx_q} > 4'(MAX_TX)) ntx0 = 4'(MAX_TX);
    else ntx0 = {1'b0, tx_q};
    case (h_c)
      3'd1:    lim = 5'd16;
      3'd2:    lim = 5'd8;
      3'd3:    lim = 5'd5;
      default: lim = 5'd4;
    endcase
    ntx_c = ({1'b0, ntx0} > lim) ? lim[3:0] : ntx0;
    if (rx_q == 3'd0) nrx_c = 4'd1;
    else if ({1'b0, rx_q} > 4'(MAX_RX)) nrx_c = 4'(MAX_RX);
    else nrx_c = {1'b0, rx_q};
    geo.ntx   = ntx_c;
    geo.nrx   = nrx_c;
    geo.h     = h_c;
    geo.tbits = 6'({1'b0, ntx_c, 1'b0} * {3'b000, h_c});
    geo.ndig  = {ntx_c, 1'b0};
  end

  mmsd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .geo_i        (geo),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  mmsd_dp #(
    .MAX_TX (MAX_TX),
    .MAX_RX (MAX_RX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .geo_i      (geo),
    .inv_nvar_i (inv_q),
    .log_map_i  (lm_q),
    .pam_lo_i   (pam_lo_q),
    .pam_hi_i   (pam_hi_q),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while results pending");

  a_first_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.bit_index == 5'd0)
    else $error("slice does not start at bit zero");

  a_bit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      out_valid_o && out_data_o.bit_index == $past(out_data_o.bit_index) + 5'd1)
    else $error("bit order broken");

  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last |=> !out_valid_o)
    else $error("result after last transfer");
`endif

endmodule
